FILE: rtl/mctt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_pkg
// shared constants and types for the periodic tick timer bank
// ----------------------------------------------------------------------------
package mctt_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int CHANNELS_MAX = 64;

    localparam int OP_W   = 2;
    localparam int CH_W   = 4;
    localparam int MS_W   = 16;
    localparam int RATE_W = 14;
    localparam int TICK_W = 16;
    localparam int MASK_W = 16;

    // wide enough to compare any channel number against any channel count
    localparam int CHX_W = 7;

    localparam int DVD_W = MS_W + RATE_W;
    localparam int DVS_W = RATE_W;
    localparam int DCNT_W = $clog2(DVD_W);

    // x / 1000 as ((x >> PRE_SH) * RECIP_125) >> RECIP_SH, exact for any DVD_W-bit x
    localparam int PRE_SH   = 3;
    localparam int RECIP_SH = 34;
    localparam int RECIP_W  = 28;
    localparam logic [RECIP_W-1:0] RECIP_125 = 28'd137438954;
    localparam int SCALE_W  = DVD_W - PRE_SH + RECIP_W;

    localparam int WORD_W = 2 * TICK_W;

    localparam int MS_PER_SEC = 1000;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(60);

    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_CONNECT    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd2;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

FILE: rtl/mctt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_ram
// counter and reload store, one write and one registered read port
// ----------------------------------------------------------------------------
module mctt_ram #(
    parameter int DEPTH = mctt_pkg::CHANNELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                           clk,
    input  wire                           we,
    input  wire  [AW-1:0]                 waddr,
    input  wire  [mctt_pkg::WORD_W-1:0]   wdata,
    input  wire                           re,
    input  wire  [AW-1:0]                 raddr,
    output logic [mctt_pkg::WORD_W-1:0]   rdata
);

    logic [mctt_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/mctt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mctt_div (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire mctt_pkg::div_req_t           req,
    output logic                              done,
    output logic [mctt_pkg::DVD_W-1:0]        quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [mctt_pkg::DCNT_W-1:0]       cnt_reg, cnt_next;
    logic [mctt_pkg::DVD_W-1:0]        dq_reg, dq_next;
    logic [mctt_pkg::DVS_W-1:0]        rem_reg, rem_next;
    logic [mctt_pkg::DVS_W-1:0]        dvs_reg, dvs_next;
    logic [mctt_pkg::DVS_W:0]          rem_sh;
    logic [mctt_pkg::DVS_W:0]          rem_sub;
    logic                              qbit;

    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[mctt_pkg::DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        qbit    = (rem_sh >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[mctt_pkg::DVD_W-2:0], qbit};
            rem_next = qbit ? rem_sub[mctt_pkg::DVS_W-1:0] : rem_sh[mctt_pkg::DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mctt_pkg::DCNT_W'(mctt_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

FILE: rtl/multi_channel_periodic_tick_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_periodic_tick_timer
// bank of periodic reload countdown timers held in a synchronous ram
// ----------------------------------------------------------------------------
// usage:
//   an item is taken on start while busy is low: operation, channel, and
//   interval_ms. each item gives one result, shown on granted_ms and
//   fired_mask for the single cycle in which done is high.
//   cfg_we writes clock_rate from cfg_wdata; write only while idle.
// sequence:
//   disconnect, unused operation or out-of-range connect: result in the
//   cycle after the item.
//   tick: a read and a write-back state per channel in turn, through the
//   single ram port pair. connect: a reciprocal multiply by 1/1000 and a
//   clamp for ticks from ms, a store, then one pass through the bit-serial
//   divider for granted ms from ticks.
//   a new item may be started in the cycle done is shown.
// reset:
//   all channels inactive, clock_rate 60; the ram holds no reset value and
//   its words are only used for active channels, which a connect has written.
// stall:
//   the receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module multi_channel_periodic_tick_timer #(
    parameter int CHANNELS = mctt_pkg::CHANNELS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [mctt_pkg::OP_W-1:0]         operation,
    input  wire  [mctt_pkg::CH_W-1:0]         channel,
    input  wire  [mctt_pkg::MS_W-1:0]         interval_ms,
    output logic                              done,
    output logic [mctt_pkg::TICK_W-1:0]       granted_ms,
    output logic [mctt_pkg::MASK_W-1:0]       fired_mask,
    input  wire                               cfg_we,
    input  wire  [mctt_pkg::RATE_W-1:0]       cfg_wdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_CLAMP  = 3'd2;
    localparam logic [2:0] S_STORE  = 3'd3;
    localparam logic [2:0] S_D2GO   = 3'd4;
    localparam logic [2:0] S_D2WAIT = 3'd5;
    localparam logic [2:0] S_TRD    = 3'd6;
    localparam logic [2:0] S_TWR    = 3'd7;

    logic [2:0]                        state_reg, state_next;
    logic [CHANNELS-1:0]               active_reg, active_next;
    logic [mctt_pkg::RATE_W-1:0]       rate_reg, rate_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic                              done_reg, done_next;
    logic [mctt_pkg::TICK_W-1:0]       granted_reg, granted_next;
    logic [mctt_pkg::MASK_W-1:0]       fired_reg, fired_next;
    logic [mctt_pkg::DVD_W-1:0]        prod_reg, prod_next;
    logic [mctt_pkg::TICK_W-1:0]       ticks_reg, ticks_next;

    logic [mctt_pkg::CHX_W-1:0]        ch_ext;
    logic [mctt_pkg::CHX_W-1:0]        idx_ext;
    logic                              ch_ok;
    logic [mctt_pkg::SCALE_W-1:0]      scaled;

    mctt_pkg::div_req_t                div_req;
    logic                              div_done;
    logic [mctt_pkg::DVD_W-1:0]        div_quot;

    logic                              ram_we;
    logic [IDX_W-1:0]                  ram_waddr;
    logic [mctt_pkg::WORD_W-1:0]       ram_wdata;
    logic                              ram_re;
    logic [mctt_pkg::WORD_W-1:0]       ram_rdata;
    logic [mctt_pkg::TICK_W-1:0]       rem_dec;
    logic [mctt_pkg::TICK_W-1:0]       reload_val;

    mctt_ram #(
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    mctt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        ch_ext     = mctt_pkg::CHX_W'(channel);
        idx_ext    = mctt_pkg::CHX_W'(idx_reg);
        ch_ok      = (ch_ext < mctt_pkg::CHX_W'(CHANNELS));
        reload_val = ram_rdata[mctt_pkg::WORD_W-1:mctt_pkg::TICK_W];
        rem_dec    = ram_rdata[mctt_pkg::TICK_W-1:0] - 1'b1;
        scaled     = mctt_pkg::SCALE_W'(prod_reg[mctt_pkg::DVD_W-1:mctt_pkg::PRE_SH])
                   * mctt_pkg::SCALE_W'(mctt_pkg::RECIP_125);

        state_next   = state_reg;
        active_next  = active_reg;
        rate_next    = cfg_we ? cfg_wdata : rate_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        fired_next   = fired_reg;
        prod_next    = prod_reg;
        ticks_next   = ticks_reg;

        div_req.go       = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = rate_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {ticks_reg, ticks_reg};
        ram_re    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next     = ch_ext[IDX_W-1:0];
                    granted_next = '0;
                    fired_next   = '0;
                    prod_next    = mctt_pkg::DVD_W'(interval_ms)
                                 * mctt_pkg::DVD_W'(rate_reg);
                    if (operation == mctt_pkg::OP_TICK)
                    begin
                        idx_next   = '0;
                        state_next = S_TRD;
                    end
                    else if (operation == mctt_pkg::OP_CONNECT && ch_ok)
                    begin
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        if (operation == mctt_pkg::OP_DISCONNECT && ch_ok)
                        begin
                            active_next[ch_ext[IDX_W-1:0]] = 1'b0;
                        end
                        done_next = 1'b1;
                    end
                end
            end
            S_SCALE:
            begin
                prod_next  = mctt_pkg::DVD_W'(scaled[mctt_pkg::SCALE_W-1:mctt_pkg::RECIP_SH]);
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (prod_reg == '0)
                begin
                    ticks_next = mctt_pkg::TICK_W'(1);
                end
                else if (prod_reg[mctt_pkg::DVD_W-1:mctt_pkg::TICK_W] != '0)
                begin
                    ticks_next = mctt_pkg::TICK_MAX;
                end
                else
                begin
                    ticks_next = prod_reg[mctt_pkg::TICK_W-1:0];
                end
                state_next = S_STORE;
            end
            S_STORE:
            begin
                ram_we               = 1'b1;
                active_next[idx_reg] = 1'b1;
                prod_next            = mctt_pkg::DVD_W'(ticks_reg)
                                     * mctt_pkg::DVD_W'(mctt_pkg::MS_PER_SEC);
                state_next           = S_D2GO;
            end
            S_D2GO:
            begin
                div_req.go = 1'b1;
                state_next = S_D2WAIT;
            end
            S_D2WAIT:
            begin
                if (div_done)
                begin
                    if (div_quot[mctt_pkg::DVD_W-1:mctt_pkg::TICK_W] != '0)
                    begin
                        granted_next = mctt_pkg::TICK_MAX;
                    end
                    else
                    begin
                        granted_next = div_quot[mctt_pkg::TICK_W-1:0];
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                ram_re     = 1'b1;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                if (active_reg[idx_reg])
                begin
                    ram_we = 1'b1;
                    if (rem_dec == '0)
                    begin
                        ram_wdata = {reload_val, reload_val};
                        for (int i = 0; i < mctt_pkg::MASK_W; i++)
                        begin
                            if (idx_ext == mctt_pkg::CHX_W'(i))
                            begin
                                fired_next[i] = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        ram_wdata = {reload_val, rem_dec};
                    end
                end
                if (idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            rate_reg   <= mctt_pkg::RATE_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            rate_reg   <= rate_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        granted_reg <= granted_next;
        fired_reg   <= fired_next;
        prod_reg    <= prod_next;
        ticks_reg   <= ticks_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign granted_ms = granted_reg;
    assign fired_mask = fired_reg;

`ifndef SYNTHESIS
    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without an item in progress");

    a_one_field_only: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (granted_ms == '0 || fired_mask == '0))
        else $error("granted and fired both set");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    a_no_fire_on_connect: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted_ms != '0) |-> $past(state_reg == S_D2WAIT))
        else $error("granted period outside a connect");
`endif

endmodule
`default_nettype wire
